>>> rtl/etv_pkg.sv
`timescale 1ns / 1ps

package etv_pkg;

    // Deepest parenthesis nesting that counts as balanced.
    localparam int MAX_DEPTH = 255;
    localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);

    // Token classes. CL_NONE marks the start of an expression.
    typedef enum logic [3:0] {
        CL_NONE  = 4'd0,
        CL_PLUS  = 4'd1,
        CL_MINUS = 4'd2,
        CL_OPEN  = 4'd3,
        CL_CLOSE = 4'd4,
        CL_ARITH = 4'd5,
        CL_NUM   = 4'd6,
        CL_OTHER = 4'd7
    } token_class_t;

    // Everything the validator carries from one character to the next.
    typedef struct packed {
        logic [7:0]         first_char;
        logic [1:0]         length;      // saturates at three
        logic [1:0]         dot_count;   // saturates at three
        logic               all_numeric;
        token_class_t       prev_class;
        logic [DEPTH_W-1:0] depth;
        logic               char_err;
        logic               paren_err;
        logic               place_err;
    } etv_state_t;

    localparam etv_state_t STATE_RESET = '{
        first_char:  8'h00,
        length:      2'd0,
        dot_count:   2'd0,
        all_numeric: 1'b1,
        prev_class:  CL_NONE,
        depth:       '0,
        char_err:    1'b0,
        paren_err:   1'b0,
        place_err:   1'b0
    };

    // Verdict for one finished expression.
    typedef struct packed {
        logic expression_ok;
        logic bad_placement;
        logic bad_parentheses;
        logic bad_character;
    } etv_result_t;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

endpackage

>>> rtl/etv_step.sv
`timescale 1ns / 1ps

// Combinational update for one character: folds the character into the
// current token, classifies the token when it ends, and produces the verdict
// when the expression ends.
module etv_step (
    input  etv_pkg::etv_state_t  state,
    input  logic [7:0]           ch,
    input  logic                 token_end,
    input  logic                 expr_end,
    output etv_pkg::etv_state_t  state_next,
    output etv_pkg::etv_result_t result
);

    function automatic etv_pkg::token_class_t op_class(input logic [7:0] c);
        etv_pkg::token_class_t k;
        case (c)
            etv_pkg::CH_PLUS:  k = etv_pkg::CL_PLUS;
            etv_pkg::CH_MINUS: k = etv_pkg::CL_MINUS;
            etv_pkg::CH_OPEN:  k = etv_pkg::CL_OPEN;
            etv_pkg::CH_CLOSE: k = etv_pkg::CL_CLOSE;
            etv_pkg::CH_STAR, etv_pkg::CH_SLASH,
            etv_pkg::CH_PCT, etv_pkg::CH_CARET: k = etv_pkg::CL_ARITH;
            default:           k = etv_pkg::CL_NONE;
        endcase
        return k;
    endfunction

    function automatic logic is_op(input etv_pkg::token_class_t c);
        return c inside {etv_pkg::CL_PLUS, etv_pkg::CL_MINUS, etv_pkg::CL_OPEN,
                         etv_pkg::CL_CLOSE, etv_pkg::CL_ARITH};
    endfunction

    function automatic logic is_sign(input etv_pkg::token_class_t c);
        return c inside {etv_pkg::CL_PLUS, etv_pkg::CL_MINUS};
    endfunction

    function automatic logic pair_bad(input etv_pkg::token_class_t a,
                                      input etv_pkg::token_class_t b);
        logic bad;
        bad = 1'b0;
        if (is_op(a) && is_op(b) &&
            !(is_sign(b) || b == etv_pkg::CL_OPEN || a == etv_pkg::CL_CLOSE))
        begin
            bad = 1'b1;
        end
        if (a == etv_pkg::CL_OPEN && b == etv_pkg::CL_CLOSE)
        begin
            bad = 1'b1;
        end
        if (is_sign(a) && is_sign(b))
        begin
            bad = 1'b1;
        end
        if (a == etv_pkg::CL_CLOSE && b == etv_pkg::CL_OPEN)
        begin
            bad = 1'b1;
        end
        if (a == etv_pkg::CL_NUM && b == etv_pkg::CL_OPEN)
        begin
            bad = 1'b1;
        end
        return bad;
    endfunction

    logic [7:0]            first_ch;
    logic [1:0]            len_upd;
    logic [1:0]            dots_upd;
    logic                  num_upd;
    logic                  char_ok;
    etv_pkg::token_class_t cls;
    logic                  cerr;
    logic                  perr;
    logic                  lerr;
    logic [etv_pkg::DEPTH_W-1:0] depth_upd;

    always_comb
    begin
        first_ch  = (state.length == 2'd0) ? ch : state.first_char;
        len_upd   = (state.length == 2'd3) ? 2'd3 : state.length + 2'd1;
        dots_upd  = (ch == etv_pkg::CH_DOT && state.dot_count != 2'd3) ?
                    state.dot_count + 2'd1 : state.dot_count;
        char_ok   = (ch >= etv_pkg::CH_ZERO && ch <= etv_pkg::CH_NINE) ||
                    ch == etv_pkg::CH_PLUS || ch == etv_pkg::CH_MINUS;
        num_upd   = state.all_numeric & char_ok;

        cerr      = state.char_err;
        perr      = state.paren_err;
        lerr      = state.place_err;
        depth_upd = state.depth;

        // Classification of the token that ends with this character.
        cls = (len_upd == 2'd1) ? op_class(first_ch) : etv_pkg::CL_NONE;
        if (cls == etv_pkg::CL_NONE)
        begin
            if (num_upd)
            begin
                cls = etv_pkg::CL_NUM;
            end
            else
            begin
                cls = etv_pkg::CL_OTHER;
                // A float needs exactly one dot and more than one character.
                if (!(dots_upd == 2'd1 && len_upd != 2'd1))
                begin
                    cerr = 1'b1;
                end
            end
        end

        if (cls == etv_pkg::CL_OPEN)
        begin
            if (state.depth >= etv_pkg::DEPTH_W'(etv_pkg::MAX_DEPTH))
            begin
                perr = 1'b1;
            end
            else
            begin
                depth_upd = state.depth + etv_pkg::DEPTH_W'(1);
            end
        end
        else if (cls == etv_pkg::CL_CLOSE)
        begin
            if (state.depth == '0)
            begin
                perr = 1'b1;
            end
            else
            begin
                depth_upd = state.depth - etv_pkg::DEPTH_W'(1);
            end
        end

        if (state.prev_class == etv_pkg::CL_NONE)
        begin
            if (is_op(cls) && !(is_sign(cls) || cls == etv_pkg::CL_OPEN))
            begin
                lerr = 1'b1;
            end
        end
        else if (pair_bad(state.prev_class, cls))
        begin
            lerr = 1'b1;
        end

        if (expr_end)
        begin
            if (is_op(cls) && cls != etv_pkg::CL_CLOSE)
            begin
                lerr = 1'b1;
            end
            if (depth_upd != '0)
            begin
                perr = 1'b1;
            end
        end

        result.bad_character   = cerr;
        result.bad_parentheses = perr;
        result.bad_placement   = lerr;
        result.expression_ok   = !(cerr || perr || lerr);

        if (expr_end)
        begin
            state_next = etv_pkg::STATE_RESET;
        end
        else if (token_end)
        begin
            state_next            = etv_pkg::STATE_RESET;
            state_next.prev_class = cls;
            state_next.depth      = depth_upd;
            state_next.char_err   = cerr;
            state_next.paren_err  = perr;
            state_next.place_err  = lerr;
        end
        else
        begin
            state_next             = state;
            state_next.first_char  = first_ch;
            state_next.length      = len_upd;
            state_next.dot_count   = dots_upd;
            state_next.all_numeric = num_upd;
        end
    end

endmodule

>>> rtl/expression_token_validator.sv
`timescale 1ns / 1ps

// Channel  | Direction | Content
// ---------+-----------+-----------------------------------------------------
// s_axis   | in        | tdata: ch; tuser: token_end; tlast: expr_end
// m_axis   | out       | tdata: bad_character, bad_parentheses, bad_placement,
//          |           |        expression_ok (bits 0..3, upper bits zero)
//
// One character is accepted per cycle unless s_axis is stalled. A character
// is held in the input register; the token and expression state is updated as
// it leaves, and a character carrying expr_end loads the verdict into the
// result register and raises m_axis_tvalid as it leaves. The result register
// holds one verdict; while it waits, further characters keep flowing, and
// only a second expression end stalls s_axis.
// rst_n clears the state to the start of an empty expression and drops all
// valid flags.
module expression_token_validator (
    input  logic       clk,
    input  logic       rst_n,

    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] ch
    input  logic       s_axis_tuser,   // [0] token_end
    input  logic       s_axis_tlast,   // expr_end

    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [0] bad_character, [1] bad_parentheses,
                                       // [2] bad_placement, [3] expression_ok
);

    // Input register.
    logic       in_valid_reg;
    logic [7:0] in_ch_reg;
    logic       in_tend_reg;
    logic       in_eend_reg;

    // Running state and result register.
    etv_pkg::etv_state_t  state_reg;
    etv_pkg::etv_state_t  state_next;
    etv_pkg::etv_result_t result_next;
    etv_pkg::etv_result_t result_reg;
    logic                 out_valid_reg;

    logic advance;
    logic in_take;

    // A character may leave the input register unless it ends an expression
    // and the result register still holds a verdict nobody has taken.
    assign advance = in_valid_reg &&
                     (!in_eend_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    etv_step u_step (
        .state      (state_reg),
        .ch         (in_ch_reg),
        .token_end  (in_tend_reg),
        .expr_end   (in_eend_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= etv_pkg::STATE_RESET;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                state_reg <= state_next;
            end

            if (advance && in_eend_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_ch_reg   <= s_axis_tdata;
            in_tend_reg <= s_axis_tuser;
            in_eend_reg <= s_axis_tlast;
        end
        if (advance && in_eend_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, result_reg.expression_ok, result_reg.bad_placement,
                            result_reg.bad_parentheses, result_reg.bad_character};

    // A new verdict only ever comes from an expression end leaving the
    // input register.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance && in_eend_reg))
        else $error("verdict appeared without an expression end");

    // After an expression ends the state is back at its reset value.
    a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_eend_reg |=> state_reg == etv_pkg::STATE_RESET)
        else $error("state not cleared after expression end");

    // A held character is neither lost nor overwritten.
    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_ch_reg))
        else $error("input register changed while stalled");

    // The ok bit agrees with the three error flags of every delivered verdict.
    a_ok_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> result_reg.expression_ok ==
            !(result_reg.bad_character || result_reg.bad_parentheses ||
              result_reg.bad_placement))
        else $error("expression_ok disagrees with error flags");

    // Nesting depth never passes the limit.
    a_depth_limit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.depth <= etv_pkg::DEPTH_W'(etv_pkg::MAX_DEPTH))
        else $error("parenthesis depth beyond limit");

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

// Bench for expression_token_validator. Characters are queued up front by an
// initial block and fed over s_axis by a clocked driver. A clocked monitor
// follows every accepted transaction on both channels. On the input side it
// runs a behavioral copy of the token classifier and the expression checker,
// and that copy queues one expected verdict per finished expression. On the
// output side it pops the oldest verdict and compares it field by field.
module tb;

    localparam int CLK_HALF       = 6;
    localparam int RANDOM_CHARS   = 700;
    localparam int CALM_TAIL      = 300;   // no idling once this few characters remain
    localparam int WATCHDOG_LIMIT = 2000;

    // One queued character together with its token and expression marks.
    // When hold is set, the driver lets every outstanding verdict drain
    // before it sends this character.
    typedef struct packed {
        logic       hold;
        logic       expr_end;
        logic       tok_end;
        logic [7:0] ch;
    } char_item_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;

    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;
    logic       s_axis_tuser = 1'b0;
    logic       s_axis_tlast = 1'b0;

    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;

    char_item_t           char_queue[$];
    etv_pkg::etv_result_t expected_verdicts[$];

    // Driver and receiver bookkeeping.
    logic hold_next = 1'b0;
    logic calm = 1'b0;
    logic draining = 1'b0;
    int   send_gap = 0;
    int   stall_left = 0;
    int   verdicts_due = 0;   // registered copy of expected_verdicts.size()
    int   idle_cycles = 0;

    // Statistics and the failure count.
    int mismatch_count = 0;
    int chars_accepted = 0;
    int verdicts_checked = 0;
    int clean_verdicts = 0;
    int deepest_nest = 0;

    // Predictor state for the expression that is currently being received.
    logic [1:0]            tok_len = 2'd0;
    logic [1:0]            tok_dots = 2'd0;
    logic                  tok_digits_only = 1'b1;
    logic [7:0]            tok_lead = 8'h00;
    etv_pkg::token_class_t last_class = etv_pkg::CL_NONE;
    int                    nest = 0;
    logic                  flag_char = 1'b0;
    logic                  flag_paren = 1'b0;
    logic                  flag_place = 1'b0;

    expression_token_validator uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Class of a one-character token; anything that is not an operator
    // character comes back as CL_NONE.
    function automatic etv_pkg::token_class_t single_char_class(input logic [7:0] c);
        case (c)
            etv_pkg::CH_PLUS:  return etv_pkg::CL_PLUS;
            etv_pkg::CH_MINUS: return etv_pkg::CL_MINUS;
            etv_pkg::CH_OPEN:  return etv_pkg::CL_OPEN;
            etv_pkg::CH_CLOSE: return etv_pkg::CL_CLOSE;
            etv_pkg::CH_STAR, etv_pkg::CH_SLASH,
            etv_pkg::CH_PCT, etv_pkg::CH_CARET: return etv_pkg::CL_ARITH;
            default:  return etv_pkg::CL_NONE;
        endcase
    endfunction

    function automatic logic is_op(input etv_pkg::token_class_t k);
        return k >= etv_pkg::CL_PLUS && k <= etv_pkg::CL_ARITH;
    endfunction

    function automatic logic is_sign(input etv_pkg::token_class_t k);
        return k == etv_pkg::CL_PLUS || k == etv_pkg::CL_MINUS;
    endfunction

    // Adjacent token pairs (a followed by b) that make the placement wrong.
    function automatic logic adjacent_bad(input etv_pkg::token_class_t a,
                                          input etv_pkg::token_class_t b);
        if (is_op(a) && is_op(b) &&
            !(is_sign(b) || b == etv_pkg::CL_OPEN || a == etv_pkg::CL_CLOSE))
            return 1'b1;
        if (a == etv_pkg::CL_OPEN && b == etv_pkg::CL_CLOSE)
            return 1'b1;
        if (is_sign(a) && is_sign(b))
            return 1'b1;
        if (a == etv_pkg::CL_CLOSE && b == etv_pkg::CL_OPEN)
            return 1'b1;
        return a == etv_pkg::CL_NUM && b == etv_pkg::CL_OPEN;
    endfunction

    task automatic clear_token();
        tok_len = 2'd0;
        tok_dots = 2'd0;
        tok_digits_only = 1'b1;
        tok_lead = 8'h00;
    endtask

    // Folds one accepted character into the predicted state. When the
    // character closes an expression, the verdict is queued and the state
    // returns to the start of an empty expression.
    task automatic absorb_char(input logic [7:0] c, input logic tend, input logic eend);
        etv_pkg::token_class_t cls;
        etv_pkg::etv_result_t  v;
        if (tok_len == 2'd0)
            tok_lead = c;
        if (tok_len != 2'd3)
            tok_len = tok_len + 2'd1;
        if (c == etv_pkg::CH_DOT && tok_dots != 2'd3)
            tok_dots = tok_dots + 2'd1;
        if (!((c >= etv_pkg::CH_ZERO && c <= etv_pkg::CH_NINE) ||
              c == etv_pkg::CH_PLUS || c == etv_pkg::CH_MINUS))
            tok_digits_only = 1'b0;

        // An expression end also closes the token that is open.
        if (tend || eend)
        begin
            cls = (tok_len == 2'd1) ? single_char_class(tok_lead) : etv_pkg::CL_NONE;
            if (cls == etv_pkg::CL_NONE)
            begin
                if (tok_digits_only)
                    cls = etv_pkg::CL_NUM;
                else
                begin
                    cls = etv_pkg::CL_OTHER;
                    // Float tokens count as legal regardless of their other characters.
                    if (!(tok_dots == 2'd1 && tok_len != 2'd1))
                        flag_char = 1'b1;
                end
            end

            // An open at full depth and a close at depth zero both leave
            // the depth where it is.
            if (cls == etv_pkg::CL_OPEN)
            begin
                if (nest >= etv_pkg::MAX_DEPTH)
                    flag_paren = 1'b1;
                else
                    nest++;
                if (nest > deepest_nest)
                    deepest_nest = nest;
            end
            else if (cls == etv_pkg::CL_CLOSE)
            begin
                if (nest == 0)
                    flag_paren = 1'b1;
                else
                    nest--;
            end

            if (last_class == etv_pkg::CL_NONE)
            begin
                if (is_op(cls) && !(is_sign(cls) || cls == etv_pkg::CL_OPEN))
                    flag_place = 1'b1;
            end
            else if (adjacent_bad(last_class, cls))
                flag_place = 1'b1;

            clear_token();

            if (!eend)
                last_class = cls;
            else
            begin
                if (is_op(cls) && cls != etv_pkg::CL_CLOSE)
                    flag_place = 1'b1;
                if (nest != 0)
                    flag_paren = 1'b1;
                v.bad_character   = flag_char;
                v.bad_parentheses = flag_paren;
                v.bad_placement   = flag_place;
                v.expression_ok   = !(flag_char || flag_paren || flag_place);
                expected_verdicts.insert(expected_verdicts.size(), v);
                last_class = etv_pkg::CL_NONE;
                nest = 0;
                flag_char = 1'b0;
                flag_paren = 1'b0;
                flag_place = 1'b0;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------

    task automatic put_char(input logic [7:0] c, input logic tend);
        char_item_t it;
        it = '0;
        it.ch = c;
        it.tok_end = tend;
        it.hold = hold_next;
        hold_next = 1'b0;
        char_queue.insert(char_queue.size(), it);
    endtask

    task automatic put_token(input string s);
        for (int i = 0; i < s.len(); i++)
            put_char(s[i], i == s.len() - 1);
    endtask

    // Marks the newest character as the end of the expression. With tend
    // low, the expression end alone has to close the last token.
    task automatic finish_expr(input logic tend);
        char_item_t it;
        it = char_queue[char_queue.size() - 1];
        it.expr_end = 1'b1;
        it.tok_end = tend;
        char_queue[char_queue.size() - 1] = it;
    endtask

    // Biased toward digits, operators and dots, but a good share of the
    // characters are arbitrary bytes, so every bit of ch toggles.
    function automatic logic [7:0] pick_char();
        string ops = "+-*/%^()";
        case ($urandom_range(0, 9))
            0, 1, 2: return 8'(etv_pkg::CH_ZERO + $urandom_range(0, 9));
            3, 4:    return ops[$urandom_range(0, 7)];
            5:       return etv_pkg::CH_DOT;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // An operand: mostly numeric or float, sometimes junk.
    task automatic put_operand();
        int         len;
        int         dot_at;
        logic [7:0] c;
        case ($urandom_range(0, 11))
            0:
            begin
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++)
                    put_char(pick_char(), i == len - 1);
            end
            1, 2, 3:
            begin
                len = $urandom_range(2, 5);
                dot_at = $urandom_range(0, len - 1);
                for (int i = 0; i < len; i++)
                begin
                    if (i == dot_at)
                        c = etv_pkg::CH_DOT;
                    else if ($urandom_range(0, 7) == 0)
                        c = 8'($urandom_range(8'h41, 8'h7A));
                    else
                        c = 8'(etv_pkg::CH_ZERO + $urandom_range(0, 9));
                    put_char(c, i == len - 1);
                end
            end
            default:
            begin
                len = $urandom_range(1, 5);
                for (int i = 0; i < len; i++)
                begin
                    if (i > 0 && $urandom_range(0, 5) == 0)
                        c = $urandom_range(0, 1) ? etv_pkg::CH_PLUS : etv_pkg::CH_MINUS;
                    else
                        c = 8'(etv_pkg::CH_ZERO + $urandom_range(0, 9));
                    put_char(c, i == len - 1);
                end
            end
        endcase
    endtask

    // Builds a mostly legal expression: operands joined by binary operators,
    // with optional unary signs and random nesting up to nest_cap.
    task automatic gen_wellformed(input int nest_cap);
        string      binops = "+-*/%^";
        int         opens;
        int         terms;
        logic       sign_before;
        logic [7:0] op;
        opens = 0;
        terms = $urandom_range(1, 6);
        sign_before = 1'b0;
        for (int t = 0; t < terms; t++)
        begin
            if (t > 0)
            begin
                op = binops[$urandom_range(0, 5)];
                put_char(op, 1'b1);
                sign_before = (op == etv_pkg::CH_PLUS || op == etv_pkg::CH_MINUS);
            end
            while (opens < nest_cap && $urandom_range(0, 3) == 0)
            begin
                put_char(etv_pkg::CH_OPEN, 1'b1);
                opens++;
                sign_before = 1'b0;
            end
            if (!sign_before && $urandom_range(0, 5) == 0)
                put_char($urandom_range(0, 1) ? etv_pkg::CH_PLUS : etv_pkg::CH_MINUS, 1'b1);
            put_operand();
            sign_before = 1'b0;
            while (opens > 0 && $urandom_range(0, 2) == 0)
            begin
                put_char(etv_pkg::CH_CLOSE, 1'b1);
                opens--;
            end
        end
        while (opens > 0)
        begin
            put_char(etv_pkg::CH_CLOSE, 1'b1);
            opens--;
        end
        finish_expr(1'($urandom_range(0, 1)));
    endtask

    // Noise: random characters with random token boundaries. The expression
    // end may therefore land in the middle of a token.
    task automatic gen_noise();
        int n;
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++)
            put_char(pick_char(), $urandom_range(0, 2) == 0);
        finish_expr(1'($urandom_range(0, 1)));
    endtask

    task automatic gen_nest(input int levels);
        for (int k = 0; k < levels; k++)
            put_char(etv_pkg::CH_OPEN, 1'b1);
        put_token("7");
        for (int k = 0; k < levels; k++)
            put_char(etv_pkg::CH_CLOSE, 1'b1);
        finish_expr(1'b1);
    endtask

    // ------------------------------------------------------------------
    // Reset, stimulus and the end of the run
    // ------------------------------------------------------------------

    initial
    begin
        int base;
        int expr_count;

        // Directed part. A legal expression whose final transaction carries
        // the expression end without the token end.
        put_token("(");
        put_token("1");
        put_token("+");
        put_token("2.5");
        put_token(")");
        put_token("*");
        put_token("3");
        finish_expr(1'b0);
        // An arithmetic operator that opens the expression.
        put_token("*");
        put_token("4");
        finish_expr(1'b1);
        // A lone dot is too short to be a float.
        put_token(".");
        finish_expr(1'b1);
        // Two dots, and a length that saturates.
        put_token("1.2.");
        finish_expr(1'b1);
        // The lowest and the highest byte values as tokens.
        put_char(8'hFF, 1'b1);
        put_token("+");
        put_char(8'h00, 1'b1);
        finish_expr(1'b1);
        // An operator that closes the expression.
        put_token("5");
        put_token("-");
        finish_expr(1'b1);
        // Two signs in a row.
        put_token("+");
        put_token("-");
        put_token("6");
        finish_expr(1'b1);
        // An open directly followed by a close.
        put_token("(");
        put_token(")");
        finish_expr(1'b1);
        // A close with nothing open, then an open left dangling.
        put_token(")");
        put_token("(");
        finish_expr(1'b1);
        // A number followed by an open.
        put_token("2");
        put_token("(");
        put_token("3");
        finish_expr(1'b1);

        // Nesting right at the limit, then one level past it. The driver
        // drains the pipeline before each one.
        hold_next = 1'b1;
        gen_nest(etv_pkg::MAX_DEPTH);
        hold_next = 1'b1;
        gen_nest(etv_pkg::MAX_DEPTH + 1);

        // Random part: mostly legal expressions with random content, plus
        // noise. Every fortieth expression starts only after a full drain.
        base = char_queue.size();
        expr_count = 0;
        while (char_queue.size() - base < RANDOM_CHARS)
        begin
            if (expr_count % 40 == 0)
                hold_next = 1'b1;
            if ($urandom_range(0, 9) < 7)
                gen_wellformed($urandom_range(0, 15) == 0 ? 30 : $urandom_range(0, 4));
            else
                gen_noise();
            expr_count++;
        end

        // Reset is held low at the start and released away from the rising edge.
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait until every character has been sent and every verdict has come,
        // then keep the clock running so that any stray output shows.
        while (char_queue.size() != 0 || s_axis_tvalid || expected_verdicts.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        $display("Sent %0d characters and checked %0d verdicts (%0d clean).",
                 chars_accepted, verdicts_checked, clean_verdicts);
        $display("Nesting reached %0d levels against a limit of %0d.",
                 deepest_nest, etv_pkg::MAX_DEPTH);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: one character per transaction, with random gaps and the
    // occasional full drain.
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : drive_chars
        char_item_t item;
        logic       show;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            // A presented transaction stays in place until it is accepted.
            show = s_axis_tvalid && !s_axis_tready;
            if (!show)
            begin
                if (draining)
                begin
                    if (verdicts_due == 0)
                        draining = 1'b0;
                end
                else if (send_gap > 0)
                    send_gap--;
                else if (char_queue.size() != 0)
                begin
                    item = char_queue[0];
                    if (item.hold)
                    begin
                        item.hold = 1'b0;
                        char_queue[0] = item;
                        draining = 1'b1;
                    end
                    else
                    begin
                        void'(char_queue.pop_front());
                        s_axis_tdata <= item.ch;
                        s_axis_tuser <= item.tok_end;
                        s_axis_tlast <= item.expr_end;
                        show = 1'b1;
                        if (!calm && $urandom_range(0, 5) == 0)
                            send_gap = $urandom_range(1, 8);
                    end
                end
            end
            s_axis_tvalid <= show;
            calm <= char_queue.size() < CALM_TAIL;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: back-pressure comes in random bursts of stalled cycles.
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 6) == 0)
        begin
            stall_left = $urandom_range(1, 8) - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Monitor: predicts verdicts from the input transactions and checks
    // the output transactions against them.
    // ------------------------------------------------------------------

    task automatic check_field(input string label, input logic want, input logic got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %b, actual %b", $time, label, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin : watch_ports
        etv_pkg::etv_result_t want;
        etv_pkg::etv_result_t got;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                absorb_char(s_axis_tdata, s_axis_tuser, s_axis_tlast);
                chars_accepted++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = etv_pkg::etv_result_t'(m_axis_tdata[3:0]);
                if (expected_verdicts.size() == 0)
                begin
                    $display("%0t ns: unexpected verdict, expected none, actual %b",
                             $time, m_axis_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    check_field("bad_character", want.bad_character, got.bad_character);
                    check_field("bad_parentheses", want.bad_parentheses, got.bad_parentheses);
                    check_field("bad_placement", want.bad_placement, got.bad_placement);
                    check_field("expression_ok", want.expression_ok, got.expression_ok);
                    if (m_axis_tdata[7:4] !== 4'h0)
                    begin
                        $display("%0t ns: tdata padding mismatch, expected 0000, actual %b",
                                 $time, m_axis_tdata[7:4]);
                        mismatch_count++;
                    end
                    verdicts_checked++;
                    if (want.expression_ok)
                        clean_verdicts++;
                end
            end
        end
        verdicts_due <= expected_verdicts.size();
    end

    // Watchdog: the run is stuck when neither channel completes a transaction
    // for a long stretch.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t ns: timeout, %0d cycles without a transaction", $time, idle_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule
